// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the responder modules.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CDR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define CDR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/cdr_pkg.sv -----
// Shared constants and controller/datapath interface types for the DNS responder.
// No dependencies.
package cdr_pkg;

	localparam int BUFFER_BYTES = 256;
	localparam int ADDR_W       = $clog2(BUFFER_BYTES);
	localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
	// Label walk can overshoot the stored length by one label plus the question tail.
	localparam int PTR_W        = $clog2(BUFFER_BYTES + 262);

	localparam int HDR_BYTES    = 12;
	localparam int QTAIL_BYTES  = 5;
	localparam int ANS_BYTES    = 16;

	// Read address selects.
	localparam logic [1:0] RD_WALK = 2'd0;
	localparam logic [1:0] RD_QHI  = 2'd1;
	localparam logic [1:0] RD_QLO  = 2'd2;
	localparam logic [1:0] RD_EMIT = 2'd3;

	typedef struct packed {
		logic       rx_write;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       walk_init;
		logic       walk_step;
		logic       qhi_load;
		logic       emit_init;
		logic       emit_byte;
		logic       clear_count;
	} cdr_cmd_t;

	typedef struct packed {
		logic hdr_ok;
		logic walk_in_range;
		logic label_zero;
		logic q_fits;
		logic emit_last;
	} cdr_status_t;

endpackage

// ----- rtl/cdr_ctrl.sv -----
// Sequencer for the DNS responder: receive, header check, label walk, emission.
// Depends on cdr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cdr_ctrl import cdr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        end_of_packet,
	input  cdr_status_t status,
	output cdr_cmd_t    cmd,
	output logic        busy
);

	localparam logic [3:0] ST_RECV      = 4'd0;
	localparam logic [3:0] ST_CHECK     = 4'd1;
	localparam logic [3:0] ST_WALK_RD   = 4'd2;
	localparam logic [3:0] ST_WALK_DAT  = 4'd3;
	localparam logic [3:0] ST_QCHK      = 4'd4;
	localparam logic [3:0] ST_QT1       = 4'd5;
	localparam logic [3:0] ST_QT2       = 4'd6;
	localparam logic [3:0] ST_EMIT_RD   = 4'd7;
	localparam logic [3:0] ST_EMIT_BYTE = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign busy = (state_q != ST_RECV);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_RECV: begin
				cmd.rx_write = start;
				if (start && end_of_packet) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.hdr_ok) begin
					cmd.walk_init = 1'b1;
					state_d       = ST_WALK_RD;
				end else begin
					cmd.clear_count = 1'b1;
					state_d         = ST_RECV;
				end
			end
			ST_WALK_RD: begin
				if (status.walk_in_range) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_WALK;
					state_d    = ST_WALK_DAT;
				end else begin
					state_d = ST_QCHK;
				end
			end
			ST_WALK_DAT: begin
				if (status.label_zero) begin
					state_d = ST_QCHK;
				end else begin
					cmd.walk_step = 1'b1;
					state_d       = ST_WALK_RD;
				end
			end
			ST_QCHK: begin
				if (status.q_fits) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_QHI;
					state_d    = ST_QT1;
				end else begin
					cmd.clear_count = 1'b1;
					state_d         = ST_RECV;
				end
			end
			ST_QT1: begin
				cmd.qhi_load = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.rd_sel   = RD_QLO;
				state_d      = ST_QT2;
			end
			ST_QT2: begin
				cmd.emit_init = 1'b1;
				state_d       = ST_EMIT_RD;
			end
			ST_EMIT_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_EMIT;
				state_d    = ST_EMIT_BYTE;
			end
			ST_EMIT_BYTE: begin
				cmd.emit_byte = 1'b1;
				if (status.emit_last) begin
					cmd.clear_count = 1'b1;
					state_d         = ST_RECV;
				end else begin
					state_d = ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_RECV;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RECV;
		end else begin
			state_q <= state_d;
		end
	end

	`CDR_ASSERT(a_busy_fall_src, $fell(busy) |-> ($past(state_q) == ST_CHECK || $past(state_q) == ST_QCHK || $past(state_q) == ST_EMIT_BYTE), "busy dropped from an unexpected state")
	`CDR_ASSERT(a_walk_read_range, (cmd.rd_en && cmd.rd_sel == RD_WALK) |-> status.walk_in_range, "label read beyond stored length")

endmodule

// ----- rtl/cdr_datapath.sv -----
// Packet store, label walk pointer, response byte builder and word packer.
// Depends on cdr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cdr_datapath import cdr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cdr_cmd_t    cmd,
	output cdr_status_t status,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_write,
	input  logic [31:0] cfg_data,
	output logic        resp_valid,
	output logic [63:0] resp_word,
	output logic [3:0]  byte_count,
	output logic        end_of_response
);

	function automatic logic [7:0] answer_byte(input logic [3:0] k, input logic [31:0] ip);
		logic [7:0] b;
		unique case (k)
			4'd0:    b = 8'hC0;
			4'd1:    b = 8'h0C;
			4'd3:    b = 8'h01;
			4'd5:    b = 8'h01;
			4'd9:    b = 8'h3C;
			4'd11:   b = 8'h04;
			4'd12:   b = ip[31:24];
			4'd13:   b = ip[23:16];
			4'd14:   b = ip[15:8];
			4'd15:   b = ip[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	logic [7:0]       mem [BUFFER_BYTES];
	logic [7:0]       rd_data_q;
	logic [ADDR_W-1:0] rd_addr;

	logic [CNT_W-1:0] count_q;
	logic [31:0]      portal_q;
	logic [7:0]       b2_q, b4_q, b5_q;
	logic [PTR_W-1:0] p_q, qend_q, txlen_q, pos_q;
	logic [7:0]       qhi_q;
	logic             is_a_q;
	logic [2:0]       lane_q;
	logic [63:0]      acc_q;
	logic             strobe_q;
	logic [63:0]      word_q;
	logic [3:0]       cnt_q;
	logic             eor_q;

	logic [PTR_W-1:0] len_ext, p_plus1, p_plus2, p_plus5, k_full;
	logic             store_room;
	logic             is_a_now;
	logic [7:0]       tx_byte;
	logic [63:0]      acc_next;

	assign len_ext    = PTR_W'(count_q);
	assign p_plus1    = p_q + PTR_W'(1);
	assign p_plus2    = p_q + PTR_W'(2);
	assign p_plus5    = p_q + PTR_W'(QTAIL_BYTES);
	assign store_room = (count_q < CNT_W'(BUFFER_BYTES));
	assign is_a_now   = (qhi_q == 8'h00) && (rd_data_q == 8'h01);
	assign k_full     = pos_q - qend_q;

	assign status.hdr_ok        = (count_q >= CNT_W'(HDR_BYTES)) && !b2_q[7]
		&& (b4_q == 8'h00) && (b5_q == 8'h01);
	assign status.walk_in_range = (p_q < len_ext);
	assign status.label_zero    = (rd_data_q == 8'h00);
	assign status.q_fits        = (p_plus5 <= len_ext);
	assign status.emit_last     = ((pos_q + PTR_W'(1)) == txlen_q);

	always_comb begin
		unique case (cmd.rd_sel)
			RD_WALK: rd_addr = p_q[ADDR_W-1:0];
			RD_QHI:  rd_addr = p_plus1[ADDR_W-1:0];
			RD_QLO:  rd_addr = p_plus2[ADDR_W-1:0];
			RD_EMIT: rd_addr = pos_q[ADDR_W-1:0];
			default: rd_addr = p_q[ADDR_W-1:0];
		endcase
	end

	// Header and question bytes with the response rewrites, then the answer record.
	always_comb begin
		priority if (pos_q >= qend_q) begin
			tx_byte = answer_byte(k_full[3:0], portal_q);
		end else if (pos_q == PTR_W'(2)) begin
			tx_byte = 8'h84 | {7'b0, b2_q[0]};
		end else if (pos_q == PTR_W'(7)) begin
			tx_byte = {7'b0, is_a_q};
		end else if (pos_q == PTR_W'(3) || pos_q == PTR_W'(6) ||
			(pos_q >= PTR_W'(8) && pos_q < PTR_W'(HDR_BYTES))) begin
			tx_byte = 8'h00;
		end else begin
			tx_byte = rd_data_q;
		end
	end

	assign acc_next = acc_q | ({56'b0, tx_byte} << {~lane_q, 3'b000});

	always_ff @(posedge clk) begin
		if (cmd.rx_write && store_room) begin
			mem[count_q[ADDR_W-1:0]] <= rx_byte;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			portal_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit_byte && (lane_q == 3'd7 || status.emit_last);
			if (cfg_write) begin
				portal_q <= cfg_data;
			end
			if (cmd.clear_count) begin
				count_q <= '0;
			end else if (cmd.rx_write && store_room) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rx_write && store_room) begin
			if (count_q == CNT_W'(2)) begin
				b2_q <= rx_byte;
			end
			if (count_q == CNT_W'(4)) begin
				b4_q <= rx_byte;
			end
			if (count_q == CNT_W'(5)) begin
				b5_q <= rx_byte;
			end
		end
		if (cmd.walk_init) begin
			p_q <= PTR_W'(HDR_BYTES);
		end else if (cmd.walk_step) begin
			p_q <= p_plus1 + PTR_W'(rd_data_q);
		end
		if (cmd.qhi_load) begin
			qhi_q <= rd_data_q;
		end
		if (cmd.emit_init) begin
			is_a_q  <= is_a_now;
			qend_q  <= p_plus5;
			txlen_q <= is_a_now ? p_plus5 + PTR_W'(ANS_BYTES) : p_plus5;
			pos_q   <= '0;
			lane_q  <= '0;
			acc_q   <= '0;
		end else if (cmd.emit_byte) begin
			pos_q <= pos_q + PTR_W'(1);
			if (lane_q == 3'd7 || status.emit_last) begin
				word_q <= acc_next;
				cnt_q  <= {1'b0, lane_q} + 4'd1;
				eor_q  <= status.emit_last;
				acc_q  <= '0;
				lane_q <= '0;
			end else begin
				acc_q  <= acc_next;
				lane_q <= lane_q + 3'd1;
			end
		end
	end

	assign resp_valid      = strobe_q;
	assign resp_word       = word_q;
	assign byte_count      = cnt_q;
	assign end_of_response = eor_q;

	`CDR_ASSERT(a_count_bound, count_q <= CNT_W'(BUFFER_BYTES), "receive count past depth")
	`CDR_ASSERT(a_short_word_last, (strobe_q && cnt_q != 4'd8) |-> eor_q, "short word not last")
	`CDR_ASSERT_NEXT(a_strobe_gap, strobe_q, !strobe_q, "response words on adjacent cycles")

endmodule

// ----- rtl/captive_dns_responder_top.sv -----
// Captive-portal DNS responder: one received byte per accepted start, busy low while receiving.
// After the final byte: header check, WALK_RD and WALK_DAT per QNAME label and closing zero (only
// WALK_RD if the walk leaves the data), QCHK to QT2 for the query type, EMIT_RD and EMIT_BYTE per
// response byte (single-port store). A word strobes in the cycle after its last byte is built.
// Reset clears the sequencer, receive count and portal address; store contents stay undefined.
// Depends on cdr_pkg, cdr_ctrl and cdr_datapath.
module captive_dns_responder_top import cdr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  rx_byte,
	input  logic        end_of_packet,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output logic        resp_valid,
	output logic [63:0] resp_word,
	output logic [3:0]  byte_count,
	output logic        end_of_response
);

	cdr_cmd_t    cmd;
	cdr_status_t status;

	assign cfg_ready = 1'b1;

	cdr_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.end_of_packet (end_of_packet),
		.status        (status),
		.cmd           (cmd),
		.busy          (busy)
	);

	cdr_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.rx_byte         (rx_byte),
		.cfg_write       (cfg_valid && cfg_ready),
		.cfg_data        (cfg_data),
		.resp_valid      (resp_valid),
		.resp_word       (resp_word),
		.byte_count      (byte_count),
		.end_of_response (end_of_response)
	);

endmodule
